// ===== hdl/ess_pkg.sv =====
// ----------------------------------------------------------------------------
// Elevator stop scheduler package
// Shared widths, codes, state and configuration types, and the floor decode.
// ----------------------------------------------------------------------------
package ess_pkg;

  localparam int MAX_FLOORS = 32;
  localparam int FLOOR_W    = 6;
  localparam int TICK_W     = 16;
  localparam int SLICE_W    = 18;
  localparam int EST_W      = 32;
  localparam int PROG_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_DOWN = 2'd1,
    OP_UP   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_DOWN = 2'd1,
    DIR_UP   = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_OPEN  = 2'd1,
    EV_CLOSE = 2'd2
  } door_ev_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOWEST  = 3'd0,
    CFG_HIGHEST = 3'd1,
    CFG_HOME    = 3'd2,
    CFG_TPF     = 3'd3,
    CFG_DOOR    = 3'd4,
    CFG_DWELL   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [FLOOR_W-1:0] lowest_floor;
    logic [FLOOR_W-1:0] highest_floor;
    logic [FLOOR_W-1:0] home_floor;
    logic [TICK_W-1:0]  ticks_per_floor;
    logic [TICK_W-1:0]  ticks_door_move;
    logic [TICK_W-1:0]  ticks_dwell;
  } ess_cfg_t;

  typedef struct packed {
    logic [FLOOR_W-1:0]    floor_pos;
    dir_t                  dir_now;
    dir_t                  dir_plan;
    logic                  door;
    logic                  passive;
    logic [SLICE_W-1:0]    slice;
    logic [EST_W-1:0]      remain;
    logic [PROG_W-1:0]     progress;
    logic [MAX_FLOORS-1:0] up_stops;
    logic [MAX_FLOORS-1:0] down_stops;
  } ess_state_t;

  // one-hot stop bit for a floor; zero for floor 0 and floors above MAX_FLOORS
  function automatic logic [MAX_FLOORS-1:0] floor_bit(input logic [FLOOR_W-1:0] f);
    logic [MAX_FLOORS-1:0] b;
    b = '0;
    for (int i = 0; i < MAX_FLOORS; i++) begin
      b[i] = (32'(f) == i + 1);
    end
    return b;
  endfunction

endpackage

// ===== hdl/elevator_stop_scheduler.sv =====
// The status word of an accepted word is registered at the accepting edge.
// Throughput: one word per cycle while no status word waits on a low out_ready.
// The car state registers double as the status word, held while out_ready is low.
// Reset (rst_n low, synchronous): car at floor 1, stopped, door shut, no stops,
// estimate and progress zero, registers at their default values.
// ----------------------------------------------------------------------------
// Elevator stop scheduler
// SCAN-style car controller: ticks advance the car, calls toggle stops.
// ----------------------------------------------------------------------------
module elevator_stop_scheduler (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_operation,
  input  logic [ess_pkg::FLOOR_W-1:0]         in_call_floor,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ess_pkg::FLOOR_W-1:0]         out_car_floor,
  output logic [1:0]                          out_moving_dir,
  output logic [1:0]                          out_planned_dir,
  output logic                                out_door_is_open,
  output logic [1:0]                          out_door_event,
  output logic signed [ess_pkg::EST_W-1:0]    out_time_left,
  output logic [ess_pkg::PROG_W-1:0]          out_progress_count,
  output logic [ess_pkg::MAX_FLOORS-1:0]      out_up_stop_mask,
  output logic [ess_pkg::MAX_FLOORS-1:0]      out_down_stop_mask,
  input  logic                                cfg_we,
  input  logic [ess_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ess_pkg::CFG_DATA_W-1:0]      cfg_data
);

  ess_pkg::ess_cfg_t   cfg_r;
  ess_pkg::ess_state_t state_r, state_nxt;
  ess_pkg::door_ev_t   ev_r, ev_nxt;
  logic                out_valid_r;
  logic                in_acc;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  ess_step u_step (
    .cur        (state_r),
    .cfg        (cfg_r),
    .op         (in_operation),
    .call_floor (in_call_floor),
    .nxt        (state_nxt),
    .ev         (ev_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lowest_floor    <= ess_pkg::FLOOR_W'(1);
      cfg_r.highest_floor   <= ess_pkg::FLOOR_W'(8);
      cfg_r.home_floor      <= ess_pkg::FLOOR_W'(1);
      cfg_r.ticks_per_floor <= ess_pkg::TICK_W'(10);
      cfg_r.ticks_door_move <= ess_pkg::TICK_W'(3);
      cfg_r.ticks_dwell     <= ess_pkg::TICK_W'(5);
    end else if (cfg_we) begin
      case (cfg_index)
        ess_pkg::CFG_LOWEST:  cfg_r.lowest_floor    <= cfg_data[ess_pkg::FLOOR_W-1:0];
        ess_pkg::CFG_HIGHEST: cfg_r.highest_floor   <= cfg_data[ess_pkg::FLOOR_W-1:0];
        ess_pkg::CFG_HOME:    cfg_r.home_floor      <= cfg_data[ess_pkg::FLOOR_W-1:0];
        ess_pkg::CFG_TPF:     cfg_r.ticks_per_floor <= cfg_data[ess_pkg::TICK_W-1:0];
        ess_pkg::CFG_DOOR:    cfg_r.ticks_door_move <= cfg_data[ess_pkg::TICK_W-1:0];
        ess_pkg::CFG_DWELL:   cfg_r.ticks_dwell     <= cfg_data[ess_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.floor_pos  <= ess_pkg::FLOOR_W'(1);
      state_r.dir_now    <= ess_pkg::DIR_STOP;
      state_r.dir_plan   <= ess_pkg::DIR_STOP;
      state_r.door       <= 1'b0;
      state_r.passive    <= 1'b0;
      state_r.slice      <= '0;
      state_r.remain     <= '0;
      state_r.progress   <= '0;
      state_r.up_stops   <= '0;
      state_r.down_stops <= '0;
      ev_r               <= ess_pkg::EV_NONE;
      out_valid_r        <= 1'b0;
    end else if (in_acc) begin
      state_r     <= state_nxt;
      ev_r        <= ev_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_car_floor      = state_r.floor_pos;
  assign out_moving_dir     = state_r.dir_now;
  assign out_planned_dir    = state_r.dir_plan;
  assign out_door_is_open   = state_r.door;
  assign out_door_event     = ev_r;
  assign out_time_left      = $signed(state_r.remain);
  assign out_progress_count = state_r.progress;
  assign out_up_stop_mask   = state_r.up_stops;
  assign out_down_stop_mask = state_r.down_stops;

  a_acc_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid)
    else $error("accepted word produced no status word");

  a_hold_without_acc: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(state_r))
    else $error("car state changed without an accepted word");

  a_door_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.door |-> state_r.dir_now == ess_pkg::DIR_STOP)
    else $error("door open while the car is travelling");

  a_call_no_door_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_operation != ess_pkg::OP_TICK |=> out_door_event == ess_pkg::EV_NONE)
    else $error("door event on a call word");

  a_idle_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_operation == ess_pkg::OP_TICK &&
    state_r.dir_now == ess_pkg::DIR_STOP && !state_r.door |=> $stable(state_r))
    else $error("tick moved an idle car");

endmodule

// ===== hdl/ess_step.sv =====
// ----------------------------------------------------------------------------
// Elevator stop scheduler: single-word update
// Next car state and door event for one tick or stop toggle.
// ----------------------------------------------------------------------------
module ess_step (
  input  ess_pkg::ess_state_t       cur,
  input  ess_pkg::ess_cfg_t         cfg,
  input  logic [1:0]                op,
  input  logic [ess_pkg::FLOOR_W-1:0] call_floor,
  output ess_pkg::ess_state_t       nxt,
  output ess_pkg::door_ev_t         ev
);

  localparam int PROD_W = ess_pkg::TICK_W + ess_pkg::FLOOR_W + 2;

  logic [ess_pkg::MAX_FLOORS-1:0] fb_fp, fb_lo, fb_hi, fb, call_fb;
  logic                           dn_empty, up_empty, dn_turn, up_turn, call_ok;
  logic                           tog_en, tog_up, nest_en;
  logic [ess_pkg::FLOOR_W-1:0]    tog_f;
  logic signed [ess_pkg::FLOOR_W:0] dlt;
  logic signed [ess_pkg::TICK_W:0]  tpf_s;
  logic signed [PROD_W-1:0]       prod;
  logic [ess_pkg::EST_W-1:0]      prod_ext, cost_up, cost_down, tpf_ext;
  logic [ess_pkg::SLICE_W-1:0]    open_end, dwell_end, close_end;
  logic [ess_pkg::TICK_W-1:0]     lim;
  logic                           hit_up, hit_dn, fb_any;
  logic [ess_pkg::MAX_FLOORS-1:0] t_up, t_down;
  logic [ess_pkg::EST_W-1:0]      t_rem;
  logic [ess_pkg::PROG_W-1:0]     t_prog;

  function automatic logic [ess_pkg::EST_W-1:0] dec_sat(input logic [ess_pkg::EST_W-1:0] v);
    if (v == '0 || v[ess_pkg::EST_W-1]) begin
      return '0;
    end
    return v - ess_pkg::EST_W'(1);
  endfunction

  assign fb_fp    = ess_pkg::floor_bit(cur.floor_pos);
  assign fb_lo    = ess_pkg::floor_bit(cfg.lowest_floor);
  assign fb_hi    = ess_pkg::floor_bit(cfg.highest_floor);
  assign call_fb  = ess_pkg::floor_bit(call_floor);
  assign call_ok  = |call_fb;
  assign dn_empty = ~|cur.down_stops;
  assign up_empty = ~|cur.up_stops;
  assign dn_turn  = (cur.floor_pos == cfg.lowest_floor) && ~|(cur.down_stops & fb_lo);
  assign up_turn  = (cur.floor_pos == cfg.highest_floor) && ~|(cur.down_stops & fb_hi);

  // door phase boundaries and travel slice limit
  assign open_end  = ess_pkg::SLICE_W'(cfg.ticks_door_move);
  assign dwell_end = open_end + ess_pkg::SLICE_W'(cfg.ticks_dwell);
  assign close_end = dwell_end + ess_pkg::SLICE_W'(cfg.ticks_door_move);
  assign lim       = (cfg.ticks_per_floor == '0) ? '0 :
                     cfg.ticks_per_floor - ess_pkg::TICK_W'(1);

  // which stop gets toggled by this word
  always_comb begin
    tog_en  = 1'b0;
    tog_up  = 1'b0;
    tog_f   = call_floor;
    nest_en = 1'b0;
    case (op)
      ess_pkg::OP_TICK: begin
        if (cur.dir_now == ess_pkg::DIR_DOWN) begin
          if (dn_empty) begin
            tog_en = 1'b1;
            tog_f  = cfg.home_floor;
          end else if (dn_turn) begin
            tog_en = 1'b1;
            tog_up = 1'b1;
            tog_f  = cfg.highest_floor;
          end
        end else if (cur.dir_now != ess_pkg::DIR_STOP) begin
          if (up_empty) begin
            tog_en = 1'b1;
            tog_f  = cfg.home_floor;
          end else if (up_turn) begin
            tog_en = 1'b1;
            tog_f  = cfg.lowest_floor;
          end
        end
      end
      ess_pkg::OP_DOWN: begin
        tog_en  = 1'b1;
        nest_en = call_ok && (cur.dir_now == ess_pkg::DIR_STOP) && !cur.door &&
                  (cur.floor_pos < call_floor);
      end
      ess_pkg::OP_UP: begin
        tog_en = 1'b1;
        tog_up = 1'b1;
      end
      default: ;
    endcase
  end

  // stop cost: tpf * (1 +/- (f - pos)) + 2 * door + dwell
  assign fb       = ess_pkg::floor_bit(tog_f);
  assign dlt      = $signed({1'b0, tog_f}) - $signed({1'b0, cur.floor_pos});
  assign tpf_s    = $signed({1'b0, cfg.ticks_per_floor});
  assign prod     = PROD_W'(tpf_s) * PROD_W'(dlt);
  assign prod_ext = {{(ess_pkg::EST_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign tpf_ext  = ess_pkg::EST_W'(cfg.ticks_per_floor);
  assign cost_up   = tpf_ext + prod_ext + ess_pkg::EST_W'(close_end);
  assign cost_down = tpf_ext - prod_ext + ess_pkg::EST_W'(close_end);

  assign hit_up = |(cur.up_stops & fb);
  assign hit_dn = |(cur.down_stops & fb);
  assign fb_any = |fb;

  always_comb begin
    t_up   = cur.up_stops;
    t_down = cur.down_stops;
    t_rem  = cur.remain;
    t_prog = cur.progress;
    if (tog_en && fb_any) begin
      if (tog_up) begin
        t_up   = cur.up_stops ^ fb;
        t_rem  = hit_up ? cur.remain - cost_up : cur.remain + cost_up;
        t_prog = hit_up ? cur.progress - 8'd2 : cur.progress + 8'd2;
      end else begin
        t_down = cur.down_stops ^ fb;
        t_rem  = hit_dn ? cur.remain - cost_down : cur.remain + cost_down;
        t_prog = hit_dn ? cur.progress - 8'd2 : cur.progress + 8'd2;
      end
    end
    // down call above an idle car also toggles the up stop there
    if (nest_en) begin
      t_up   = cur.up_stops ^ fb;
      t_rem  = hit_up ? t_rem - cost_up : t_rem + cost_up;
      t_prog = hit_up ? t_prog - 8'd2 : t_prog + 8'd2;
    end
  end

  always_comb begin
    nxt            = cur;
    nxt.up_stops   = t_up;
    nxt.down_stops = t_down;
    nxt.remain     = t_rem;
    nxt.progress   = t_prog;
    ev             = ess_pkg::EV_NONE;
    case (op)
      ess_pkg::OP_TICK: begin
        if (cur.dir_now == ess_pkg::DIR_STOP) begin
          if (cur.door) begin
            if (cur.slice < open_end) begin
              if (cur.slice == '0) begin
                ev = ess_pkg::EV_OPEN;
              end
              nxt.slice  = cur.slice + 1'b1;
              nxt.remain = dec_sat(cur.remain);
            end else if (cur.slice < dwell_end) begin
              nxt.slice  = cur.slice + 1'b1;
              nxt.remain = dec_sat(cur.remain);
            end else if (cur.slice < close_end) begin
              if (cur.slice == dwell_end) begin
                ev = ess_pkg::EV_CLOSE;
              end
              nxt.slice  = cur.slice + 1'b1;
              nxt.remain = dec_sat(cur.remain);
            end else if (cur.dir_plan == ess_pkg::DIR_DOWN &&
                         cur.floor_pos == cfg.lowest_floor) begin
              // bottom reached: clear the trip and plan upwards
              ev             = ess_pkg::EV_CLOSE;
              nxt.progress   = '0;
              nxt.slice      = '0;
              nxt.remain     = '0;
              nxt.dir_plan   = ess_pkg::DIR_UP;
              nxt.door       = 1'b0;
              nxt.down_stops = cur.down_stops & ~fb_fp;
            end else begin
              if (cur.dir_plan == ess_pkg::DIR_DOWN) begin
                nxt.dir_now    = ess_pkg::DIR_DOWN;
                nxt.door       = 1'b0;
                nxt.down_stops = cur.down_stops & ~fb_fp;
              end else if (cur.dir_plan == ess_pkg::DIR_UP) begin
                if (cur.floor_pos == cfg.highest_floor) begin
                  nxt.dir_plan = ess_pkg::DIR_DOWN;
                  nxt.dir_now  = ess_pkg::DIR_DOWN;
                end else begin
                  nxt.dir_now  = ess_pkg::DIR_UP;
                end
                nxt.door     = 1'b0;
                nxt.up_stops = cur.up_stops & ~fb_fp;
              end
              nxt.progress = cur.progress - 1'b1;
              nxt.slice    = '0;
              nxt.remain   = dec_sat(cur.remain);
            end
          end
        end else if (cur.dir_now == ess_pkg::DIR_DOWN) begin
          if (dn_empty) begin
            nxt.dir_plan = ess_pkg::DIR_DOWN;
            nxt.dir_now  = ess_pkg::DIR_DOWN;
          end else if (dn_turn) begin
            nxt.dir_plan = ess_pkg::DIR_UP;
            nxt.dir_now  = ess_pkg::DIR_UP;
          end else if (cur.slice < ess_pkg::SLICE_W'(lim)) begin
            nxt.slice  = cur.slice + 1'b1;
            nxt.remain = cur.remain - 1'b1;
          end else if (|(cur.down_stops & fb_fp)) begin
            nxt.dir_now  = ess_pkg::DIR_STOP;
            nxt.dir_plan = ess_pkg::DIR_DOWN;
            nxt.door     = 1'b1;
            nxt.progress = cur.progress - 1'b1;
            nxt.slice    = '0;
            nxt.remain   = cur.remain - 1'b1;
          end else begin
            if (cur.floor_pos > ess_pkg::FLOOR_W'(1)) begin
              nxt.floor_pos = cur.floor_pos - 1'b1;
            end
            nxt.slice  = '0;
            nxt.remain = cur.remain - 1'b1;
          end
        end else begin
          if (up_empty || up_turn) begin
            nxt.dir_plan = ess_pkg::DIR_DOWN;
            nxt.dir_now  = ess_pkg::DIR_DOWN;
          end else if (cur.slice < ess_pkg::SLICE_W'(lim)) begin
            nxt.slice  = cur.slice + 1'b1;
            nxt.remain = cur.remain - 1'b1;
          end else if (|(cur.up_stops & fb_fp)) begin
            if (cur.passive) begin
              nxt.dir_plan = ess_pkg::DIR_DOWN;
              nxt.up_stops = cur.up_stops & ~fb_fp;
              nxt.passive  = 1'b0;
            end else begin
              nxt.dir_plan = cur.dir_now;
            end
            nxt.dir_now  = ess_pkg::DIR_STOP;
            nxt.door     = 1'b1;
            nxt.progress = cur.progress - 1'b1;
            nxt.slice    = '0;
            nxt.remain   = cur.remain - 1'b1;
          end else begin
            if (cur.floor_pos < ess_pkg::FLOOR_W'(63) &&
                32'(cur.floor_pos) < ess_pkg::MAX_FLOORS) begin
              nxt.floor_pos = cur.floor_pos + 1'b1;
            end
            nxt.slice  = '0;
            nxt.remain = cur.remain - 1'b1;
          end
        end
      end
      ess_pkg::OP_DOWN: begin
        if (call_ok && cur.dir_now == ess_pkg::DIR_STOP && !cur.door) begin
          if (cur.floor_pos > call_floor) begin
            nxt.dir_plan = ess_pkg::DIR_DOWN;
            nxt.dir_now  = ess_pkg::DIR_DOWN;
          end else if (cur.floor_pos < call_floor) begin
            nxt.dir_plan = ess_pkg::DIR_UP;
            nxt.dir_now  = ess_pkg::DIR_UP;
            nxt.passive  = 1'b1;
          end
        end
      end
      ess_pkg::OP_UP: begin
        if (call_ok && cur.dir_now == ess_pkg::DIR_STOP && !cur.door) begin
          if (cur.floor_pos < call_floor) begin
            nxt.dir_plan = ess_pkg::DIR_UP;
            nxt.dir_now  = ess_pkg::DIR_UP;
          end else if (cur.floor_pos > call_floor) begin
            nxt.dir_plan = ess_pkg::DIR_DOWN;
            nxt.dir_now  = ess_pkg::DIR_DOWN;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== tb/car_status_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Car status checker
// Watches the call/tick and status channels of the elevator stop scheduler,
// keeps its own copy of the car state and registers, predicts the status
// word for every accepted word and compares it field by field, in order.
// ----------------------------------------------------------------------------
module car_status_checker
  import ess_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            in_operation,
  input  logic [FLOOR_W-1:0]    in_call_floor,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [FLOOR_W-1:0]    out_car_floor,
  input  logic [1:0]            out_moving_dir,
  input  logic [1:0]            out_planned_dir,
  input  logic                  out_door_is_open,
  input  logic [1:0]            out_door_event,
  input  logic [EST_W-1:0]      out_time_left,
  input  logic [PROG_W-1:0]     out_progress_count,
  input  logic [MAX_FLOORS-1:0] out_up_stop_mask,
  input  logic [MAX_FLOORS-1:0] out_down_stop_mask,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    words_checked
);

  typedef struct packed {
    logic [FLOOR_W-1:0]    car_floor;
    logic [1:0]            moving;
    logic [1:0]            planned;
    logic                  door;
    logic [1:0]            door_ev;
    logic [EST_W-1:0]      left;
    logic [PROG_W-1:0]     progress;
    logic [MAX_FLOORS-1:0] ups;
    logic [MAX_FLOORS-1:0] downs;
  } car_status_t;

  car_status_t status_due[$];
  int errs = 0;
  int waiting = 0;
  int seen = 0;

  assign fail_count    = errs;
  assign pending       = waiting;
  assign words_checked = seen;

  // registers
  logic [FLOOR_W-1:0] lo_f, hi_f, home_f;
  logic [TICK_W-1:0]  tpf, door_t, dwell_t;

  // car state
  logic [FLOOR_W-1:0]    car_at;
  dir_t                  heading, intent;
  logic                  door_r, passive_r;
  logic [31:0]           slice_r;
  logic [EST_W-1:0]      est_r;
  logic [PROG_W-1:0]     prog_r;
  logic [MAX_FLOORS-1:0] ups, downs;

  function automatic logic [MAX_FLOORS-1:0] stop_bit(input logic [FLOOR_W-1:0] f);
    if (f == 0 || f > MAX_FLOORS) return '0;
    return 32'd1 << (f - 6'd1);
  endfunction

  function automatic void ease_estimate();
    if (est_r == 0 || est_r[EST_W-1]) est_r = '0;
    else est_r = est_r - 32'd1;
  endfunction

  function automatic logic [31:0] trip_cost(input logic [31:0] span);
    return 32'(tpf) * span + 32'd2 * 32'(door_t) + 32'(dwell_t);
  endfunction

  function automatic void call_up(input logic [FLOOR_W-1:0] f);
    logic [MAX_FLOORS-1:0] b;
    logic [31:0] cost;
    b = stop_bit(f);
    if (b == 0) return;
    cost = trip_cost(32'd1 + 32'(f) - 32'(car_at));
    if ((ups & b) != 0) begin
      ups    = ups & ~b;
      prog_r = prog_r - 8'd2;
      est_r  = est_r - cost;
    end else begin
      ups    = ups | b;
      prog_r = prog_r + 8'd2;
      est_r  = est_r + cost;
    end
    if (heading == DIR_STOP && !door_r) begin
      if (car_at < f) begin
        heading = DIR_UP;
        intent  = DIR_UP;
      end else if (car_at > f) begin
        heading = DIR_DOWN;
        intent  = DIR_DOWN;
      end
    end
  endfunction

  function automatic void call_down(input logic [FLOOR_W-1:0] f);
    logic [MAX_FLOORS-1:0] b;
    logic [31:0] cost;
    b = stop_bit(f);
    if (b == 0) return;
    cost = trip_cost(32'd1 + 32'(car_at) - 32'(f));
    if ((downs & b) != 0) begin
      downs  = downs & ~b;
      prog_r = prog_r - 8'd2;
      est_r  = est_r - cost;
    end else begin
      downs  = downs | b;
      prog_r = prog_r + 8'd2;
      est_r  = est_r + cost;
    end
    if (heading == DIR_STOP && !door_r) begin
      if (car_at > f) begin
        heading = DIR_DOWN;
        intent  = DIR_DOWN;
      end else if (car_at < f) begin
        // down call above an idle car: travel up and take it on the way
        heading   = DIR_UP;
        intent    = DIR_UP;
        passive_r = 1'b1;
        call_up(f);
      end
    end
  endfunction

  function automatic door_ev_t advance_car();
    door_ev_t ev;
    logic [31:0] dm, dw, lim;
    ev  = EV_NONE;
    dm  = 32'(door_t);
    dw  = 32'(dwell_t);
    lim = (tpf == 0) ? 32'd0 : 32'(tpf) - 32'd1;
    case (heading)
      DIR_STOP: begin
        if (!door_r) return EV_NONE;
        if (slice_r < dm) begin
          if (slice_r == 0) ev = EV_OPEN;
          slice_r++;
          ease_estimate();
        end else if (slice_r < dm + dw) begin
          slice_r++;
          ease_estimate();
        end else if (slice_r < 32'd2 * dm + dw) begin
          if (slice_r == dm + dw) ev = EV_CLOSE;
          slice_r++;
          ease_estimate();
        end else begin
          if (intent == DIR_DOWN) begin
            if (car_at == lo_f) begin
              prog_r  = '0;
              slice_r = '0;
              est_r   = '0;
              intent  = DIR_UP;
              heading = DIR_STOP;
              door_r  = 1'b0;
              downs   = downs & ~stop_bit(car_at);
              return EV_CLOSE;
            end
            heading = intent;
            door_r  = 1'b0;
            downs   = downs & ~stop_bit(car_at);
          end else if (intent == DIR_UP) begin
            if (car_at == hi_f) begin
              intent  = DIR_DOWN;
              heading = DIR_DOWN;
            end else begin
              heading = intent;
            end
            door_r = 1'b0;
            ups    = ups & ~stop_bit(car_at);
          end
          prog_r  = prog_r - 8'd1;
          slice_r = '0;
          ease_estimate();
        end
      end
      DIR_DOWN: begin
        if (downs == 0) begin
          heading = DIR_DOWN;
          intent  = DIR_DOWN;
          call_down(home_f);
        end else if (car_at == lo_f && (downs & stop_bit(lo_f)) == 0) begin
          heading = DIR_UP;
          intent  = DIR_UP;
          call_up(hi_f);
        end else if (slice_r < lim) begin
          slice_r++;
          est_r = est_r - 32'd1;
        end else if ((downs & stop_bit(car_at)) != 0) begin
          heading = DIR_STOP;
          intent  = DIR_DOWN;
          door_r  = 1'b1;
          prog_r  = prog_r - 8'd1;
          slice_r = '0;
          est_r   = est_r - 32'd1;
        end else begin
          if (car_at > 1) car_at = car_at - 6'd1;
          slice_r = '0;
          est_r   = est_r - 32'd1;
        end
      end
      default: begin
        if (ups == 0) begin
          heading = DIR_DOWN;
          intent  = DIR_DOWN;
          call_down(home_f);
        end else if (car_at == hi_f && (downs & stop_bit(hi_f)) == 0) begin
          heading = DIR_DOWN;
          intent  = DIR_DOWN;
          call_down(lo_f);
        end else if (slice_r < lim) begin
          slice_r++;
          est_r = est_r - 32'd1;
        end else if ((ups & stop_bit(car_at)) != 0) begin
          if (passive_r) begin
            intent    = DIR_DOWN;
            ups       = ups & ~stop_bit(car_at);
            passive_r = 1'b0;
          end else begin
            intent = heading;
          end
          heading = DIR_STOP;
          door_r  = 1'b1;
          prog_r  = prog_r - 8'd1;
          slice_r = '0;
          est_r   = est_r - 32'd1;
        end else begin
          if (car_at < MAX_FLOORS) car_at = car_at + 6'd1;
          slice_r = '0;
          est_r   = est_r - 32'd1;
        end
      end
    endcase
    return ev;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin : watch
    car_status_t want, got;
    door_ev_t ev;
    if (!rst_n) begin
      lo_f      = 6'd1;
      hi_f      = 6'd8;
      home_f    = 6'd1;
      tpf       = 16'd10;
      door_t    = 16'd3;
      dwell_t   = 16'd5;
      car_at    = 6'd1;
      heading   = DIR_STOP;
      intent    = DIR_STOP;
      door_r    = 1'b0;
      passive_r = 1'b0;
      slice_r   = '0;
      est_r     = '0;
      prog_r    = '0;
      ups       = '0;
      downs     = '0;
      status_due.delete();
      waiting <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_car_floor, out_moving_dir, out_planned_dir, out_door_is_open,
                out_door_event, out_time_left, out_progress_count,
                out_up_stop_mask, out_down_stop_mask};
        seen++;
        if (status_due.size() == 0) begin
          $display("%0t: status word with nothing expected, got %0h", $time, got);
          errs++;
        end else begin
          want = status_due.pop_front();
          check_field("car_floor", 32'(want.car_floor), 32'(got.car_floor));
          check_field("moving_dir", 32'(want.moving), 32'(got.moving));
          check_field("planned_dir", 32'(want.planned), 32'(got.planned));
          check_field("door_is_open", 32'(want.door), 32'(got.door));
          check_field("door_event", 32'(want.door_ev), 32'(got.door_ev));
          check_field("time_left", want.left, got.left);
          check_field("progress_count", 32'(want.progress), 32'(got.progress));
          check_field("up_stop_mask", want.ups, got.ups);
          check_field("down_stop_mask", want.downs, got.downs);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOWEST:  lo_f    = cfg_data[FLOOR_W-1:0];
          CFG_HIGHEST: hi_f    = cfg_data[FLOOR_W-1:0];
          CFG_HOME:    home_f  = cfg_data[FLOOR_W-1:0];
          CFG_TPF:     tpf     = cfg_data;
          CFG_DOOR:    door_t  = cfg_data;
          CFG_DWELL:   dwell_t = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        ev = EV_NONE;
        case (in_operation)
          OP_TICK: ev = advance_car();
          OP_DOWN: call_down(in_call_floor);
          OP_UP:   call_up(in_call_floor);
          default: ;
        endcase
        status_due.push_back('{car_at, heading, intent, door_r, ev, est_r, prog_r,
                               ups, downs});
      end
      waiting <= status_due.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elevator stop scheduler testbench
// Drives directed and random tick/call words through several register
// settings and idle patterns; the checker predicts and compares every
// status word and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import ess_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_operation = OP_TICK;
  logic [FLOOR_W-1:0]    in_call_floor = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [FLOOR_W-1:0]    out_car_floor;
  logic [1:0]            out_moving_dir;
  logic [1:0]            out_planned_dir;
  logic                  out_door_is_open;
  logic [1:0]            out_door_event;
  logic signed [EST_W-1:0] out_time_left;
  logic [PROG_W-1:0]     out_progress_count;
  logic [MAX_FLOORS-1:0] out_up_stop_mask;
  logic [MAX_FLOORS-1:0] out_down_stop_mask;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count, pending, words_checked;
  int send_pct = 0;
  int stall_pct = 0;
  int words_sent = 0;
  int settings_used = 1;
  int cur_lo = 1;
  int cur_hi = 8;

  elevator_stop_scheduler dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation, .in_call_floor,
    .out_valid, .out_ready, .out_car_floor, .out_moving_dir, .out_planned_dir,
    .out_door_is_open, .out_door_event, .out_time_left, .out_progress_count,
    .out_up_stop_mask, .out_down_stop_mask, .cfg_we, .cfg_index, .cfg_data
  );

  car_status_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation, .in_call_floor,
    .out_valid, .out_ready, .out_car_floor, .out_moving_dir, .out_planned_dir,
    .out_door_is_open, .out_door_event, .out_time_left, .out_progress_count,
    .out_up_stop_mask, .out_down_stop_mask, .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .pending, .words_checked
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  task automatic send_word(input logic [1:0] op, input logic [FLOOR_W-1:0] fl);
    if (send_pct > 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_call_floor <= fl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic send_random(input int n);
    logic [1:0] op;
    logic [FLOOR_W-1:0] fl;
    int r, lo, hi;
    lo = (cur_lo < cur_hi) ? cur_lo : cur_hi;
    hi = (cur_lo < cur_hi) ? cur_hi : cur_lo;
    if (lo < 1) lo = 1;
    if (hi > MAX_FLOORS) hi = MAX_FLOORS;
    if (lo > hi) lo = hi;
    for (int i = 0; i < n; i++) begin
      r  = $urandom_range(99);
      op = OP_TICK;
      fl = 6'($urandom_range(63));
      if (r < 68) begin
        op = OP_TICK;
      end else if (r < 92) begin
        op = $urandom_range(1) ? OP_UP : OP_DOWN;
        fl = 6'($urandom_range(hi, lo));
      end else if (r < 96) begin
        op = $urandom_range(1) ? OP_UP : OP_DOWN;
        fl = 6'($urandom_range(MAX_FLOORS, 1));
      end else if (r < 98) begin
        op = $urandom_range(1) ? OP_UP : OP_DOWN;
        fl = $urandom_range(3) == 0 ? 6'd0 : 6'($urandom_range(63, MAX_FLOORS + 1));
      end else begin
        op = OP_UNUSED;
      end
      send_word(op, fl);
    end
  endtask

  task automatic run_phase(input int lo, input int hi, input int home,
                           input int tpf, input int dm, input int dw,
                           input int s_pct, input int r_pct, input int n);
    drain();
    set_reg(CFG_LOWEST, 16'(lo));
    set_reg(CFG_HIGHEST, 16'(hi));
    set_reg(CFG_HOME, 16'(home));
    set_reg(CFG_TPF, 16'(tpf));
    set_reg(CFG_DOOR, 16'(dm));
    set_reg(CFG_DWELL, 16'(dw));
    cfg_we    <= 1'b0;
    cur_lo    = lo;
    cur_hi    = hi;
    send_pct  = s_pct;
    stall_pct = r_pct;
    settings_used++;
    send_random(n);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle tick, unused op, out-of-range floors, passive down call
    send_word(OP_TICK, 6'd63);
    send_word(OP_UNUSED, 6'd63);
    send_word(OP_UP, 6'd0);
    send_word(OP_DOWN, 6'd33);
    send_word(OP_UP, 6'd63);
    send_word(OP_DOWN, 6'd5);
    send_word(OP_UP, 6'd32);
    send_word(OP_UP, 6'd32);
    send_word(OP_DOWN, 6'd1);
    send_word(OP_UP, 6'd1);
    repeat (12) send_word(OP_TICK, 6'd0);
    send_random(60);

    run_phase(1, 8, 1, 2, 1, 2, 0, 0, 150);
    run_phase(1, 32, 5, 1, 0, 0, 55, 0, 150);
    run_phase(3, 12, 7, 0, 2, 1, 0, 55, 150);
    run_phase(0, 40, 45, 1, 1, 0, 28, 28, 140);
    run_phase(4, 9, 32, 65535, 65535, 65535, 0, 0, 60);
    run_phase(2, 6, 3, 1, 1, 1, 28, 28, 120);

    drain();
    $display("Covered %0d words and %0d status words over %0d register settings,",
             words_sent, words_checked, settings_used);
    $display("with idle-free, sender-idle, receiver-stall and mixed stretches.");
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ess_pkg.sv
hdl/ess_step.sv
hdl/elevator_stop_scheduler.sv
tb/car_status_checker.sv
tb/tb.sv
